[rtl/core/trsc_pkg.sv]
package trsc_pkg;

	// letter and contact width, fixed by the field widths
	localparam int LW = 5;
	localparam int SEL_W = 2;
	localparam int N_ROTORS = 3;

	// queue depths between and after the two halves
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	// request opcodes
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ENC   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// rotor selects
	localparam logic [SEL_W-1:0] ROT_FAST = 2'd0;
	localparam logic [SEL_W-1:0] ROT_MID  = 2'd1;
	localparam logic [SEL_W-1:0] ROT_SLOW = 2'd2;

	// classified request handed from front to back
	typedef struct packed {
		logic                         is_load;
		logic [SEL_W-1:0]             sel;
		logic [LW-1:0]                idx;
		logic [LW-1:0]                val;
		logic [LW-1:0]                letter;
		logic [N_ROTORS-1:0][LW-1:0]  off;
	} item_t;

endpackage

[rtl/core/trsc_queue.sv]
module trsc_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          wr_en;
	logic          rd_en;

	// status and handshake qualification
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign dout  = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/core/trsc_front.sv]
module trsc_front import trsc_pkg::*; #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       op,
	input  logic [SEL_W-1:0] rotor_select,
	input  logic [LW-1:0]    wire_index,
	input  logic [LW-1:0]    wire_value,
	input  logic [LW-1:0]    plain_letter,
	input  logic             mid_full,
	output logic             mid_push,
	output item_t            mid_item
);

	localparam logic [LW:0]   A_EXT = (LW + 1)'(ALPHABET_SIZE);
	localparam logic [LW-1:0] LAST  = LW'(ALPHABET_SIZE - 1);

	logic [N_ROTORS-1:0][LW-1:0] off_q;
	logic [N_ROTORS-1:0][LW-1:0] off_d;
	logic [N_ROTORS-1:0][LW-1:0] stepped;
	logic [LW-1:0]               red_tab [2**LW];
	logic                        acc;
	logic                        load_ok;
	op_t                         opc;

	// letter reduction table, built at elaboration
	for (genvar g = 0; g < 2**LW; g++) begin : g_red
		assign red_tab[g] = LW'(g % ALPHABET_SIZE);
	end

	assign full = mid_full;
	assign acc  = push && !mid_full;
	assign opc  = op_t'(op);

	// load legality: real rotor and in-range contacts
	assign load_ok = (rotor_select inside {ROT_FAST, ROT_MID, ROT_SLOW})
		&& ({1'b0, wire_index} < A_EXT) && ({1'b0, wire_value} < A_EXT);

	// odometer step of the rotor offsets
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int r = 0; r < N_ROTORS; r++) begin
			stepped[r] = off_q[r];
			if (carry) begin
				if (off_q[r] == LAST) begin
					stepped[r] = '0;
				end else begin
					stepped[r] = off_q[r] + 1'b1;
					carry = 1'b0;
				end
			end
		end
	end

	// classify the request
	always_comb begin
		mid_push = 1'b0;
		off_d    = off_q;
		case (opc)
			OP_LOAD: begin
				mid_push = acc && load_ok;
			end
			OP_ENC: begin
				mid_push = acc;
				if (acc) begin
					off_d = stepped;
				end
			end
			OP_CLEAR: begin
				if (acc) begin
					off_d = '0;
				end
			end
			default: begin
				mid_push = 1'b0;
			end
		endcase
	end

	// request handed to the back half carries the offsets before stepping
	always_comb begin
		mid_item.is_load = (opc == OP_LOAD);
		mid_item.sel     = rotor_select;
		mid_item.idx     = wire_index;
		mid_item.val     = wire_value;
		mid_item.letter  = red_tab[plain_letter];
		mid_item.off     = off_q;
	end

	// rotor offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else begin
			off_q <= off_d;
		end
	end

endmodule

[rtl/core/trsc_back.sv]
module trsc_back import trsc_pkg::*; #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  item_t         in_item,
	output logic          in_take,
	input  logic          pop,
	output logic          empty,
	output logic [LW-1:0] cipher_letter
);

	localparam int          AW    = $clog2(ALPHABET_SIZE);
	localparam int          NLK   = 2 * N_ROTORS;
	localparam int          CNT_W = $clog2(OUT_DEPTH + 1);
	localparam logic [LW:0] A_EXT = (LW + 1)'(ALPHABET_SIZE);

	// modular helpers on values below the alphabet size
	function automatic logic [LW-1:0] add_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= A_EXT) begin
			s = s - A_EXT;
		end
		return s[LW-1:0];
	endfunction

	function automatic logic [LW-1:0] sub_mod(input logic [LW-1:0] x, input logic [LW-1:0] c);
		logic [LW:0] s;
		s = {1'b0, x} + A_EXT - {1'b0, c};
		if (s >= A_EXT) begin
			s = s - A_EXT;
		end
		return s[LW-1:0];
	endfunction

	function automatic logic [LW-1:0] reflect(input logic [LW-1:0] x);
		logic [LW-1:0] r;
		r = x ^ LW'(1);
		return ({1'b0, r} < A_EXT) ? r : x;
	endfunction

	logic           vld_s  [1:NLK];
	item_t          item_s [1:NLK];
	logic [LW-1:0]  rd_s   [1:NLK];
	logic [CNT_W-1:0] cnt_q;
	logic           issue_enc;
	logic           pop_ok;
	logic           out_push;
	logic [LW-1:0]  res;

	// issue when a load, or when a result queue slot is free to reserve
	assign in_take   = in_vld && (in_item.is_load || (cnt_q < CNT_W'(OUT_DEPTH)));
	assign issue_enc = in_take && !in_item.is_load;
	assign pop_ok    = pop && !empty;

	// six lookups: inverse fast, middle, slow, then wiring slow, middle, fast
	for (genvar j = 0; j < NLK; j++) begin : g_lk
		localparam int   ROTN = (j < N_ROTORS) ? j : (NLK - 1 - j);
		localparam int   PREV = (j == 0) ? 0 : ((j - 1 < N_ROTORS) ? j - 1 : (NLK - j));
		localparam bit   INV  = (j < N_ROTORS);

		logic          cur_vld;
		item_t         cur;
		logic [LW-1:0] xin;
		logic [AW-1:0] addr;
		logic [AW-1:0] wa;
		logic [LW-1:0] wd;
		logic [LW-1:0] mem [ALPHABET_SIZE];

		// letter entering this lookup
		if (j == 0) begin : g_head
			assign cur_vld = in_take;
			assign cur     = in_item;
			assign xin     = in_item.letter;
		end else if (j == N_ROTORS) begin : g_refl
			assign cur_vld = vld_s[j];
			assign cur     = item_s[j];
			assign xin     = reflect(add_mod(item_s[j].off[PREV], rd_s[j]));
		end else begin : g_mid
			assign cur_vld = vld_s[j];
			assign cur     = item_s[j];
			assign xin     = add_mod(item_s[j].off[PREV], rd_s[j]);
		end

		assign addr = AW'(sub_mod(xin, cur.off[ROTN]));

		// loads write this table as they pass its read point
		if (INV) begin : g_winv
			assign wa = AW'(cur.val);
			assign wd = cur.idx;
		end else begin : g_wwir
			assign wa = AW'(cur.idx);
			assign wd = cur.val;
		end

		// table and stage registers
		always_ff @(posedge clk) begin
			if (cur_vld && cur.is_load && (cur.sel == SEL_W'(ROTN))) begin
				mem[wa] <= wd;
			end
			rd_s[j + 1]   <= mem[addr];
			item_s[j + 1] <= cur;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j + 1] <= 1'b0;
			end else begin
				vld_s[j + 1] <= cur_vld;
			end
		end
	end

	// last offset add gives the cipher letter
	assign res      = add_mod(item_s[NLK].off[0], rd_s[NLK]);
	assign out_push = vld_s[NLK] && !item_s[NLK].is_load;

	// slots held by letters in flight or waiting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (issue_enc && !pop_ok) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (pop_ok && !issue_enc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// result queue
	trsc_queue #(
		.W     (LW),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (res),
		.full   (),
		.pop    (pop),
		.dout   (cipher_letter),
		.empty  (empty)
	);

endmodule

[rtl/core/three_rotor_substitution_cipher_core.sv]
// channel   | handshake         | fields
// ----------+-------------------+----------------------------------------------------
// request   | push / full       | op, rotor_select, wire_index, wire_value, plain_letter
// result    | empty / pop       | cipher_letter
//
// one request per cycle is taken while the middle queue has room; letters flow
// through six table lookups, each one registered, and then into the result queue.
// loads and offset clears give no result.
// reset clears offsets and queues; wiring tables hold nothing until loaded.
// a stalled result side backs up the result queue, then the middle queue, then full.
module three_rotor_substitution_cipher_core import trsc_pkg::*; #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       op,
	input  logic [SEL_W-1:0] rotor_select,
	input  logic [LW-1:0]    wire_index,
	input  logic [LW-1:0]    wire_value,
	input  logic [LW-1:0]    plain_letter,
	output logic             empty,
	input  logic             pop,
	output logic [LW-1:0]    cipher_letter
);

	logic  mid_full;
	logic  mid_push;
	logic  mid_empty;
	logic  mid_take;
	item_t mid_in;
	item_t mid_out;

	// accept and classify requests, step offsets
	trsc_front #(
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.rotor_select (rotor_select),
		.wire_index   (wire_index),
		.wire_value   (wire_value),
		.plain_letter (plain_letter),
		.mid_full     (mid_full),
		.mid_push     (mid_push),
		.mid_item     (mid_in)
	);

	// decoupling queue
	trsc_queue #(
		.W     ($bits(item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_take),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	// lookup pipeline and result queue
	trsc_back #(
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (!mid_empty),
		.in_item       (mid_out),
		.in_take       (mid_take),
		.pop           (pop),
		.empty         (empty),
		.cipher_letter (cipher_letter)
	);

endmodule

[rtl/core/trsc_checker.sv]
module trsc_checker import trsc_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input logic [1:0]    op,
	input logic          empty,
	input logic          pop,
	input logic [LW-1:0] cipher_letter
);

	logic [7:0] pend_q;
	logic       enc_acc;
	logic       res_acc;

	assign enc_acc = push && !full && (op == OP_ENC);
	assign res_acc = pop && !empty;

	// letters taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (enc_acc && !res_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_acc && !enc_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// no result without an outstanding letter
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == '0) |-> empty)
		else $error("result shown with no letter outstanding");

	// a waiting result is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result vanished");

	// a waiting result keeps its value
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(cipher_letter))
		else $error("waiting result changed");

	// reset leaves both sides idle
	a_reset: assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("not idle in reset");

endmodule

bind three_rotor_substitution_cipher_core trsc_checker u_chk (.*);
